// ===== rtl/pl0_pkg.sv =====
// Shared types, constants and helpers of the PL/0 stack machine step unit.
`timescale 1ns / 1ps

package pl0_pkg;

	localparam int STACK_DEPTH       = 4096;
	localparam int PROGRAM_DEPTH     = 1024;
	localparam int MAX_LEVEL         = 15;
	localparam int DYNAMIC_LINK_SLOT = 1;
	localparam int RETURN_SLOT       = 2;
	localparam int STATIC_LINK_SLOT  = 3;

	localparam int WORD_W = 32;
	localparam int SAW    = $clog2(STACK_DEPTH);
	localparam int SPW    = SAW + 1;
	localparam int PAW    = $clog2(PROGRAM_DEPTH);
	localparam int LVW    = 8;
	localparam int XW     = WORD_W + 2;

	localparam int RET_REACH  = (DYNAMIC_LINK_SLOT > RETURN_SLOT) ?
		DYNAMIC_LINK_SLOT : RETURN_SLOT;
	localparam int CALL_REACH = (RET_REACH > STATIC_LINK_SLOT) ?
		RET_REACH : STATIC_LINK_SLOT;

	localparam logic signed [XW-1:0] DEPTH_X = XW'(STACK_DEPTH);

	typedef enum logic [4:0] {
		OP_LA    = 5'd0,  OP_LV  = 5'd1,  OP_LC   = 5'd2,  OP_LI   = 5'd3,
		OP_INC   = 5'd4,  OP_DEC = 5'd5,  OP_JMP  = 5'd6,  OP_FJMP = 5'd7,
		OP_HALT  = 5'd8,  OP_STORE = 5'd9, OP_CALL = 5'd10, OP_RET = 5'd11,
		OP_RI    = 5'd12, OP_WI  = 5'd13, OP_WL   = 5'd14, OP_ADD  = 5'd15,
		OP_SUB   = 5'd16, OP_MUL = 5'd17, OP_DIV  = 5'd18, OP_MOD  = 5'd19,
		OP_NEG   = 5'd20, OP_ODD = 5'd21, OP_EQ   = 5'd22, OP_NE   = 5'd23,
		OP_GT    = 5'd24, OP_GE  = 5'd25, OP_LT   = 5'd26, OP_LE   = 5'd27
	} op_t;

	typedef enum logic [1:0] {
		FLT_NONE  = 2'd0,
		FLT_DIV0  = 2'd1,
		FLT_RANGE = 2'd2,
		FLT_LEVEL = 2'd3
	} fault_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_WALK, S_WALK_RX, S_RD1, S_RD2,
		S_CALL2, S_CALL3, S_DIV, S_WB
	} state_t;

	typedef struct packed {
		logic              we;
		logic [SAW-1:0]    waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [SAW-1:0]    raddr;
	} ram_req_t;

	typedef struct packed {
		logic                  done;
		fault_t                flt;
		logic                  hlt;
		logic [PAW-1:0]        npc;
		logic signed [SPW-1:0] sp_n;
		logic [SAW-1:0]        bp_n;
		logic                  wv;
		logic [WORD_W-1:0]     wval;
		logic                  nl;
	} fin_t;

	function automatic logic in_stack(input logic signed [XW-1:0] a);
		return (a >= 0) && (a < DEPTH_X);
	endfunction

	function automatic logic is_binary(input op_t op);
		return (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) ||
			(op == OP_DIV) || (op == OP_MOD) || (op == OP_EQ) ||
			(op == OP_NE) || (op == OP_GT) || (op == OP_GE) ||
			(op == OP_LT) || (op == OP_LE);
	endfunction

endpackage

// ===== rtl/pl0_stack_machine_step_unit.sv =====
// Top level of the PL/0 stack machine step unit: sequencer around the stack RAM.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  operation, p_operand, q_operand, read_value
//   out      output     out_valid/ out_stall next_pc, write_valid, write_value, newline,
//                                            halted, fault
//
// LC, JMP and WL finish in the execute state; two-operand arithmetic goes on through two
// reads and a write-back, each static-link level walked adds a read, and DIV and MOD also
// wait for the divider. The stack RAM has a single read port and registered read data.
// After reset a clearing pass writes zero to every one of the STACK_DEPTH (4096) stack
// words, one word per cycle; no request is accepted during that pass.
// A finished result waits in the output register; the next request may be accepted
// while it waits, and the sequencer only halts when a second result would overwrite it.
`timescale 1ns / 1ps

module pl0_stack_machine_step_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [4:0]                        operation,
	input  logic signed [31:0]                p_operand,
	input  logic signed [31:0]                q_operand,
	input  logic signed [31:0]                read_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pl0_pkg::PAW-1:0]           next_pc,
	output logic                              write_valid,
	output logic signed [31:0]                write_value,
	output logic                              newline,
	output logic                              halted,
	output logic [1:0]                        fault
);

	localparam int W   = pl0_pkg::WORD_W;
	localparam int XW  = pl0_pkg::XW;
	localparam int SAW = pl0_pkg::SAW;
	localparam int SPW = pl0_pkg::SPW;
	localparam int PAW = pl0_pkg::PAW;

	// Sequencer state and architectural registers.
	pl0_pkg::state_t               state_q, state_n;
	logic [SAW-1:0]                clr_q;
	logic [PAW-1:0]                pc_q;
	logic signed [SPW-1:0]         sp_q;
	logic [SAW-1:0]                bp_q;
	logic                          stopped_q;

	// The instruction being executed and its working registers.
	pl0_pkg::op_t                  op_q;
	logic signed [W-1:0]           p_q, q_q, rv_q;
	logic signed [W-1:0]           r_q;
	logic [pl0_pkg::LVW-1:0]       cnt_q;
	logic signed [W-1:0]           x_q;
	logic [SAW-1:0]                addr_q;
	logic signed [W-1:0]           res_q;

	pl0_pkg::fin_t                 act;
	pl0_pkg::ram_req_t             ram;
	logic signed [W-1:0]           rdata;
	logic                          step;
	logic                          in_acc;

	// Address arithmetic is done two bits wider than a word so no check can wrap.
	logic signed [XW-1:0] sp_x, sp_p1, sp_m1, sp_m2, bp_x, bp_m1, r_x, p_x, q_x, rd_x;
	logic signed [XW-1:0] inc_a, dec_a, walk_a, lv_a, call_top, call_dl, call_ra, call_sl;
	logic signed [XW-1:0] ret_top, ret_dl, ret_ra;
	logic [PAW-1:0]       pc_inc;

	logic signed [2*W-1:0] prod;
	logic signed [W-1:0]   alu_res;
	logic                  div_start;
	logic signed [W-1:0]   div_quo, div_rem;
	logic                  div_done;

	assign sp_x     = XW'(sp_q);
	assign sp_p1    = sp_x + 1;
	assign sp_m1    = sp_x - 1;
	assign sp_m2    = sp_x - 2;
	assign bp_x     = $signed(XW'(bp_q));
	assign bp_m1    = bp_x - 1;
	assign r_x      = XW'(r_q);
	assign p_x      = XW'(p_q);
	assign q_x      = XW'(q_q);
	assign rd_x     = XW'(rdata);
	assign inc_a    = sp_x + p_x;
	assign dec_a    = sp_x - p_x;
	assign walk_a   = r_x + pl0_pkg::STATIC_LINK_SLOT;
	assign lv_a     = r_x + q_x;
	assign call_top = sp_p1 + pl0_pkg::CALL_REACH;
	assign call_dl  = sp_p1 + pl0_pkg::DYNAMIC_LINK_SLOT;
	assign call_ra  = sp_p1 + pl0_pkg::RETURN_SLOT;
	assign call_sl  = sp_p1 + pl0_pkg::STATIC_LINK_SLOT;
	assign ret_top  = bp_x + pl0_pkg::RET_REACH;
	assign ret_dl   = bp_x + pl0_pkg::DYNAMIC_LINK_SLOT;
	assign ret_ra   = bp_x + pl0_pkg::RETURN_SLOT;
	assign pc_inc   = pc_q + 1'b1;

	assign in_stall = (state_q != pl0_pkg::S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// A finishing step waits while the previous result has not yet been taken.
	assign step = !(act.done && out_valid && out_stall);

	// Two-operand arithmetic and comparisons, combinational; the result is registered in res_q.
	assign prod = x_q * rdata;

	always_comb begin
		unique case (op_q)
			pl0_pkg::OP_ADD: alu_res = x_q + rdata;
			pl0_pkg::OP_SUB: alu_res = x_q - rdata;
			pl0_pkg::OP_MUL: alu_res = prod[W-1:0];
			pl0_pkg::OP_EQ:  alu_res = W'(x_q == rdata);
			pl0_pkg::OP_NE:  alu_res = W'(x_q != rdata);
			pl0_pkg::OP_GT:  alu_res = W'(x_q > rdata);
			pl0_pkg::OP_GE:  alu_res = W'(x_q >= rdata);
			pl0_pkg::OP_LT:  alu_res = W'(x_q < rdata);
			pl0_pkg::OP_LE:  alu_res = W'(x_q <= rdata);
			default:         alu_res = '0;
		endcase
	end

	assign div_start = step && (state_q == pl0_pkg::S_RD2) &&
		((op_q == pl0_pkg::OP_DIV) || (op_q == pl0_pkg::OP_MOD)) && (rdata != '0);

	// Per-state actions: stack RAM requests and the result of a finishing step.
	always_comb begin
		act      = '0;
		act.flt  = pl0_pkg::FLT_NONE;
		act.npc  = pc_inc;
		act.sp_n = sp_q;
		act.bp_n = bp_q;
		ram      = '0;
		unique case (state_q)
			pl0_pkg::S_CLEAR: begin
				ram.we    = 1'b1;
				ram.waddr = clr_q;
			end
			pl0_pkg::S_IDLE: begin
			end
			pl0_pkg::S_EXEC: begin
				if (stopped_q) begin
					act.done = 1'b1;
					act.hlt  = 1'b1;
				end else begin
					unique case (op_q)
						pl0_pkg::OP_LA, pl0_pkg::OP_LV, pl0_pkg::OP_CALL: begin
							if (p_q < 0 || p_q > pl0_pkg::MAX_LEVEL) begin
								act.done = 1'b1;
								act.flt  = pl0_pkg::FLT_LEVEL;
							end
						end
						pl0_pkg::OP_LC: begin
							act.done = 1'b1;
							if (sp_p1 >= pl0_pkg::DEPTH_X) begin
								act.flt = pl0_pkg::FLT_RANGE;
							end else begin
								ram.we    = 1'b1;
								ram.waddr = sp_p1[SAW-1:0];
								ram.wdata = p_q;
								act.sp_n  = sp_p1[SPW-1:0];
							end
						end
						pl0_pkg::OP_LI, pl0_pkg::OP_FJMP, pl0_pkg::OP_RI, pl0_pkg::OP_WI,
						pl0_pkg::OP_NEG, pl0_pkg::OP_ODD: begin
							if (sp_q < 0) begin
								act.done = 1'b1;
								act.flt  = pl0_pkg::FLT_RANGE;
							end else begin
								ram.re    = 1'b1;
								ram.raddr = sp_q[SAW-1:0];
							end
						end
						pl0_pkg::OP_INC, pl0_pkg::OP_DEC: begin
							act.done = 1'b1;
							if (op_q == pl0_pkg::OP_INC) begin
								if (inc_a < -1 || inc_a >= pl0_pkg::DEPTH_X) begin
									act.flt = pl0_pkg::FLT_RANGE;
								end else begin
									act.sp_n = inc_a[SPW-1:0];
								end
							end else begin
								if (dec_a < -1 || dec_a >= pl0_pkg::DEPTH_X) begin
									act.flt = pl0_pkg::FLT_RANGE;
								end else begin
									act.sp_n = dec_a[SPW-1:0];
								end
							end
						end
						pl0_pkg::OP_JMP: begin
							act.done = 1'b1;
							act.npc  = p_q[PAW-1:0];
						end
						pl0_pkg::OP_HALT: begin
							act.done = 1'b1;
							act.hlt  = 1'b1;
						end
						pl0_pkg::OP_STORE, pl0_pkg::OP_ADD, pl0_pkg::OP_SUB, pl0_pkg::OP_MUL,
						pl0_pkg::OP_DIV, pl0_pkg::OP_MOD, pl0_pkg::OP_EQ, pl0_pkg::OP_NE,
						pl0_pkg::OP_GT, pl0_pkg::OP_GE, pl0_pkg::OP_LT, pl0_pkg::OP_LE: begin
							if (sp_q < 1) begin
								act.done = 1'b1;
								act.flt  = pl0_pkg::FLT_RANGE;
							end else begin
								ram.re    = 1'b1;
								ram.raddr = sp_m1[SAW-1:0];
							end
						end
						pl0_pkg::OP_RET: begin
							if (ret_top >= pl0_pkg::DEPTH_X) begin
								act.done = 1'b1;
								act.flt  = pl0_pkg::FLT_RANGE;
							end else begin
								ram.re    = 1'b1;
								ram.raddr = ret_dl[SAW-1:0];
							end
						end
						pl0_pkg::OP_WL: begin
							act.done = 1'b1;
							act.nl   = 1'b1;
						end
						default: begin
							act.done = 1'b1;
						end
					endcase
				end
			end
			pl0_pkg::S_WALK: begin
				if (cnt_q != '0) begin
					if (!pl0_pkg::in_stack(walk_a)) begin
						act.done = 1'b1;
						act.flt  = pl0_pkg::FLT_RANGE;
					end else begin
						ram.re    = 1'b1;
						ram.raddr = walk_a[SAW-1:0];
					end
				end else begin
					unique case (op_q)
						pl0_pkg::OP_LA: begin
							act.done = 1'b1;
							if (sp_p1 >= pl0_pkg::DEPTH_X) begin
								act.flt = pl0_pkg::FLT_RANGE;
							end else begin
								ram.we    = 1'b1;
								ram.waddr = sp_p1[SAW-1:0];
								ram.wdata = lv_a[W-1:0];
								act.sp_n  = sp_p1[SPW-1:0];
							end
						end
						pl0_pkg::OP_LV: begin
							if (sp_p1 >= pl0_pkg::DEPTH_X || !pl0_pkg::in_stack(lv_a)) begin
								act.done = 1'b1;
								act.flt  = pl0_pkg::FLT_RANGE;
							end else begin
								ram.re    = 1'b1;
								ram.raddr = lv_a[SAW-1:0];
							end
						end
						pl0_pkg::OP_CALL: begin
							if (call_top >= pl0_pkg::DEPTH_X) begin
								act.done = 1'b1;
								act.flt  = pl0_pkg::FLT_RANGE;
							end else begin
								ram.we    = 1'b1;
								ram.waddr = call_dl[SAW-1:0];
								ram.wdata = W'(bp_q);
							end
						end
						default: begin
							act.done = 1'b1;
						end
					endcase
				end
			end
			pl0_pkg::S_WALK_RX: begin
			end
			pl0_pkg::S_RD1: begin
				unique case (op_q)
					pl0_pkg::OP_LV: begin
						act.done  = 1'b1;
						ram.we    = 1'b1;
						ram.waddr = sp_p1[SAW-1:0];
						ram.wdata = rdata;
						act.sp_n  = sp_p1[SPW-1:0];
					end
					pl0_pkg::OP_LI, pl0_pkg::OP_STORE, pl0_pkg::OP_RET, pl0_pkg::OP_RI: begin
						if (!pl0_pkg::in_stack(rd_x)) begin
							act.done = 1'b1;
							act.flt  = pl0_pkg::FLT_RANGE;
						end else if (op_q == pl0_pkg::OP_LI) begin
							ram.re    = 1'b1;
							ram.raddr = rdata[SAW-1:0];
						end else if (op_q == pl0_pkg::OP_STORE) begin
							ram.re    = 1'b1;
							ram.raddr = sp_q[SAW-1:0];
						end else if (op_q == pl0_pkg::OP_RET) begin
							ram.re    = 1'b1;
							ram.raddr = ret_ra[SAW-1:0];
						end else begin
							act.done  = 1'b1;
							ram.we    = 1'b1;
							ram.waddr = rdata[SAW-1:0];
							ram.wdata = rv_q;
							act.sp_n  = sp_m1[SPW-1:0];
						end
					end
					pl0_pkg::OP_FJMP: begin
						act.done = 1'b1;
						act.sp_n = sp_m1[SPW-1:0];
						if (rdata == '0) begin
							act.npc = p_q[PAW-1:0];
						end
					end
					pl0_pkg::OP_WI: begin
						act.done = 1'b1;
						act.wv   = 1'b1;
						act.wval = rdata;
						act.sp_n = sp_m1[SPW-1:0];
					end
					pl0_pkg::OP_NEG, pl0_pkg::OP_ODD: begin
						act.done  = 1'b1;
						ram.we    = 1'b1;
						ram.waddr = sp_q[SAW-1:0];
						ram.wdata = (op_q == pl0_pkg::OP_NEG) ? -rdata : (rdata & W'(1));
					end
					default: begin
						if (pl0_pkg::is_binary(op_q)) begin
							ram.re    = 1'b1;
							ram.raddr = sp_q[SAW-1:0];
						end else begin
							act.done = 1'b1;
						end
					end
				endcase
			end
			pl0_pkg::S_RD2: begin
				unique case (op_q)
					pl0_pkg::OP_LI: begin
						act.done  = 1'b1;
						ram.we    = 1'b1;
						ram.waddr = sp_q[SAW-1:0];
						ram.wdata = rdata;
					end
					pl0_pkg::OP_STORE: begin
						act.done  = 1'b1;
						ram.we    = 1'b1;
						ram.waddr = addr_q;
						ram.wdata = rdata;
						act.sp_n  = sp_m2[SPW-1:0];
					end
					pl0_pkg::OP_RET: begin
						act.done = 1'b1;
						act.npc  = rdata[PAW-1:0];
						act.sp_n = bp_m1[SPW-1:0];
						act.bp_n = addr_q;
					end
					pl0_pkg::OP_DIV, pl0_pkg::OP_MOD: begin
						if (rdata == '0) begin
							act.done = 1'b1;
							act.flt  = pl0_pkg::FLT_DIV0;
						end
					end
					default: begin
						if (!pl0_pkg::is_binary(op_q)) begin
							act.done = 1'b1;
						end
					end
				endcase
			end
			pl0_pkg::S_CALL2: begin
				ram.we    = 1'b1;
				ram.waddr = call_ra[SAW-1:0];
				ram.wdata = W'(pc_inc);
			end
			pl0_pkg::S_CALL3: begin
				// The static link goes last so it wins if slots coincide.
				act.done  = 1'b1;
				ram.we    = 1'b1;
				ram.waddr = call_sl[SAW-1:0];
				ram.wdata = r_q;
				act.npc   = q_q[PAW-1:0];
				act.bp_n  = sp_p1[SAW-1:0];
			end
			pl0_pkg::S_DIV: begin
			end
			pl0_pkg::S_WB: begin
				act.done  = 1'b1;
				ram.we    = 1'b1;
				ram.waddr = sp_m1[SAW-1:0];
				ram.wdata = res_q;
				act.sp_n  = sp_m1[SPW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Next-state logic.
	always_comb begin
		state_n = state_q;
		if (act.done) begin
			state_n = pl0_pkg::S_IDLE;
		end else begin
			unique case (state_q)
				pl0_pkg::S_CLEAR:   state_n = (clr_q == '1) ? pl0_pkg::S_IDLE : pl0_pkg::S_CLEAR;
				pl0_pkg::S_IDLE:    state_n = in_acc ? pl0_pkg::S_EXEC : pl0_pkg::S_IDLE;
				pl0_pkg::S_EXEC: begin
					if (op_q == pl0_pkg::OP_LA || op_q == pl0_pkg::OP_LV ||
						op_q == pl0_pkg::OP_CALL) begin
						state_n = pl0_pkg::S_WALK;
					end else begin
						state_n = pl0_pkg::S_RD1;
					end
				end
				pl0_pkg::S_WALK: begin
					if (cnt_q != '0) begin
						state_n = pl0_pkg::S_WALK_RX;
					end else if (op_q == pl0_pkg::OP_CALL) begin
						state_n = pl0_pkg::S_CALL2;
					end else begin
						state_n = pl0_pkg::S_RD1;
					end
				end
				pl0_pkg::S_WALK_RX: state_n = pl0_pkg::S_WALK;
				pl0_pkg::S_RD1:     state_n = pl0_pkg::S_RD2;
				pl0_pkg::S_RD2: begin
					if (op_q == pl0_pkg::OP_DIV || op_q == pl0_pkg::OP_MOD) begin
						state_n = pl0_pkg::S_DIV;
					end else begin
						state_n = pl0_pkg::S_WB;
					end
				end
				pl0_pkg::S_CALL2:   state_n = pl0_pkg::S_CALL3;
				pl0_pkg::S_CALL3:   state_n = pl0_pkg::S_IDLE;
				pl0_pkg::S_DIV:     state_n = div_done ? pl0_pkg::S_WB : pl0_pkg::S_DIV;
				pl0_pkg::S_WB:      state_n = pl0_pkg::S_IDLE;
				default:            state_n = pl0_pkg::S_IDLE;
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pl0_pkg::S_CLEAR;
			clr_q     <= '0;
			pc_q      <= '0;
			sp_q      <= '1;
			bp_q      <= '0;
			stopped_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (step) begin
				state_q <= state_n;
			end
			if (state_q == pl0_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (step && act.done) begin
				out_valid <= 1'b1;
				if (act.flt != pl0_pkg::FLT_NONE || act.hlt) begin
					stopped_q <= 1'b1;
				end else begin
					pc_q <= act.npc;
					sp_q <= act.sp_n;
					bp_q <= act.bp_n;
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Instruction, working and result registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= pl0_pkg::op_t'(operation);
			p_q  <= p_operand;
			q_q  <= q_operand;
			rv_q <= read_value;
		end
		if (step) begin
			unique case (state_q)
				pl0_pkg::S_EXEC: begin
					r_q   <= W'(bp_q);
					cnt_q <= p_q[pl0_pkg::LVW-1:0];
				end
				pl0_pkg::S_WALK_RX: begin
					r_q   <= rdata;
					cnt_q <= cnt_q - 1'b1;
				end
				pl0_pkg::S_RD1: begin
					x_q    <= rdata;
					addr_q <= rdata[SAW-1:0];
				end
				pl0_pkg::S_RD2: begin
					res_q <= alu_res;
				end
				pl0_pkg::S_DIV: begin
					if (div_done) begin
						res_q <= (op_q == pl0_pkg::OP_MOD) ? div_rem : div_quo;
					end
				end
				default: begin
				end
			endcase
			if (act.done) begin
				next_pc     <= (act.flt != pl0_pkg::FLT_NONE || act.hlt) ? pc_q : act.npc;
				write_valid <= act.wv;
				write_value <= act.wval;
				newline     <= act.nl;
				halted      <= (act.flt != pl0_pkg::FLT_NONE) || act.hlt;
				fault       <= act.flt;
			end
		end
	end

	// Reads and writes never touch the same word in overlapping cycles: no instruction reads
	// after it has written, and the idle state lies between its last write and the next read.
	pl0_stack_ram #(
		.AW(SAW),
		.DW(W)
	) u_ram (
		.clk   (clk),
		.we    (ram.we && step),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re && step),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

	pl0_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (x_q),
		.divisor   (rdata),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	a_stopped_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stopped flag cleared without reset");

	a_sp_floor: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q >= -1)
		else $error("stack pointer below minus one");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pl0_pkg::S_IDLE) |-> !ram.we)
		else $error("stack write while idle");

	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault != pl0_pkg::FLT_NONE) |-> halted)
		else $error("fault reported without halt");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (rdata != '0) && !stopped_q)
		else $error("divider started with zero divisor");

endmodule

// ===== rtl/pl0_stack_ram.sv =====
// Single-port-write, single-port-read synchronous RAM holding the data stack.
`timescale 1ns / 1ps

module pl0_stack_ram #(
	parameter int AW = 12,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/pl0_divider.sv =====
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module pl0_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [pl0_pkg::WORD_W-1:0] dividend,
	input  logic signed [pl0_pkg::WORD_W-1:0] divisor,
	output logic signed [pl0_pkg::WORD_W-1:0] quotient,
	output logic signed [pl0_pkg::WORD_W-1:0] remainder,
	output logic                            done
);

	localparam int CW = $clog2(pl0_pkg::WORD_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CW-1:0]             cnt_q;
	logic [pl0_pkg::WORD_W-1:0] rem_q;
	logic [pl0_pkg::WORD_W-1:0] quo_q;
	logic [pl0_pkg::WORD_W-1:0] den_q;
	logic                      negq_q;
	logic                      negr_q;
	logic [pl0_pkg::WORD_W:0]  rem_sh;
	logic [pl0_pkg::WORD_W:0]  diff;

	assign rem_sh = {rem_q, quo_q[pl0_pkg::WORD_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == '1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Magnitudes are taken in unsigned form, so the most negative value works too.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend[pl0_pkg::WORD_W-1] ? -dividend : dividend;
			den_q  <= divisor[pl0_pkg::WORD_W-1] ? -divisor : divisor;
			rem_q  <= '0;
			negq_q <= dividend[pl0_pkg::WORD_W-1] ^ divisor[pl0_pkg::WORD_W-1];
			negr_q <= dividend[pl0_pkg::WORD_W-1];
		end else if (busy_q) begin
			if (!diff[pl0_pkg::WORD_W]) begin
				rem_q <= diff[pl0_pkg::WORD_W-1:0];
				quo_q <= {quo_q[pl0_pkg::WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[pl0_pkg::WORD_W-1:0];
				quo_q <= {quo_q[pl0_pkg::WORD_W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = negq_q ? -$signed(quo_q) : $signed(quo_q);
	assign remainder = negr_q ? -$signed(rem_q) : $signed(rem_q);
	assign done      = done_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the PL/0 stack machine step unit.
`timescale 1ns / 1ps

module tb;
	import pl0_pkg::*;

	// Opcode 31 is not assigned and must behave as a no-operation.
	localparam logic [4:0] OP_SPARE = 5'd31;
	// Cycles without any handshake before the run is declared hung. This covers the
	// clearing pass after reset, the long receiver hold and the slowest division.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [PAW-1:0] npc;
		logic           wv;
		logic [31:0]    wval;
		logic           nl;
		logic           hlt;
		logic [1:0]     flt;
	} step_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [4:0] operation;
	logic signed [31:0] p_operand;
	logic signed [31:0] q_operand;
	logic signed [31:0] read_value;
	logic out_valid;
	logic out_stall;
	logic [PAW-1:0] next_pc;
	logic write_valid;
	logic signed [31:0] write_value;
	logic newline;
	logic halted;
	logic [1:0] fault;

	pl0_stack_machine_step_unit dut (.*);

	// The testbench's own copy of the machine: data stack and registers.
	logic [31:0] stk_mem [STACK_DEPTH];
	logic [PAW-1:0] pc_reg;
	longint sp_reg;
	longint bp_reg;
	bit stopped_reg;

	step_result_t pending_steps [$];
	int failures;
	bit burst;
	int hold_left;
	int out_wait;
	int idle_cycles;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic bit stack_ok(input longint a);
		return a >= 0 && a < STACK_DEPTH;
	endfunction

	function automatic longint word_at(input longint a);
		return longint'($signed(stk_mem[a]));
	endfunction

	// Follows the static links up the given number of levels from the current frame.
	function automatic fault_t walk_links(input longint lvl, output longint base);
		longint r;
		r = bp_reg;
		base = 0;
		if (lvl < 0 || lvl > MAX_LEVEL) begin
			return FLT_LEVEL;
		end
		for (longint i = 0; i < lvl; i++) begin
			if (!stack_ok(r + STATIC_LINK_SLOT)) begin
				return FLT_RANGE;
			end
			r = word_at(r + STATIC_LINK_SLOT);
		end
		base = r;
		return FLT_NONE;
	endfunction

	// Works out the result of one instruction. With commit clear nothing is changed,
	// so the stimulus side can ask whether an instruction would stop the machine.
	function automatic step_result_t execute(input bit commit, input logic [4:0] opc,
			input logic signed [31:0] p, input logic signed [31:0] q,
			input logic signed [31:0] rv);
		step_result_t r;
		longint sp_n, bp_n, a, b, x, y, v;
		logic [PAW-1:0] npc;
		fault_t f;
		bit hlt;
		int nw;
		longint wa [3];
		logic [31:0] wd [3];
		r = '0;
		if (stopped_reg) begin
			r.npc = pc_reg;
			r.hlt = 1'b1;
			return r;
		end
		npc = pc_reg + 1'b1;
		sp_n = sp_reg;
		bp_n = bp_reg;
		f = FLT_NONE;
		hlt = 1'b0;
		nw = 0;
		case (opc)
			OP_LA, OP_LV: begin
				f = walk_links(p, b);
				if (f == FLT_NONE) begin
					a = b + q;
					if (sp_n + 1 >= STACK_DEPTH || (opc == OP_LV && !stack_ok(a))) begin
						f = FLT_RANGE;
					end else begin
						sp_n++;
						wa[0] = sp_n;
						wd[0] = (opc == OP_LA) ? a[31:0] : stk_mem[a];
						nw = 1;
					end
				end
			end
			OP_LC: begin
				if (sp_n + 1 >= STACK_DEPTH) begin
					f = FLT_RANGE;
				end else begin
					sp_n++;
					wa[0] = sp_n;
					wd[0] = p;
					nw = 1;
				end
			end
			OP_LI: begin
				if (sp_n < 0 || !stack_ok(word_at(sp_n))) begin
					f = FLT_RANGE;
				end else begin
					wa[0] = sp_n;
					wd[0] = stk_mem[word_at(sp_n)];
					nw = 1;
				end
			end
			OP_INC, OP_DEC: begin
				a = (opc == OP_INC) ? sp_n + p : sp_n - p;
				if (a < -1 || a >= STACK_DEPTH) begin
					f = FLT_RANGE;
				end else begin
					sp_n = a;
				end
			end
			OP_JMP: npc = p[PAW-1:0];
			OP_FJMP: begin
				if (sp_n < 0) begin
					f = FLT_RANGE;
				end else begin
					if (stk_mem[sp_n] == 0) begin
						npc = p[PAW-1:0];
					end
					sp_n--;
				end
			end
			OP_HALT: hlt = 1'b1;
			OP_STORE: begin
				if (sp_n < 1 || !stack_ok(word_at(sp_n - 1))) begin
					f = FLT_RANGE;
				end else begin
					wa[0] = word_at(sp_n - 1);
					wd[0] = stk_mem[sp_n];
					nw = 1;
					sp_n -= 2;
				end
			end
			OP_CALL: begin
				f = walk_links(p, b);
				if (f == FLT_NONE) begin
					a = sp_n + 1;
					if (!stack_ok(a) || !stack_ok(a + DYNAMIC_LINK_SLOT) ||
							!stack_ok(a + RETURN_SLOT) || !stack_ok(a + STATIC_LINK_SLOT)) begin
						f = FLT_RANGE;
					end else begin
						// Written in this order so that coinciding slots resolve as specified.
						wa[0] = a + DYNAMIC_LINK_SLOT;
						wd[0] = bp_n[31:0];
						wa[1] = a + RETURN_SLOT;
						wd[1] = 32'(npc);
						wa[2] = a + STATIC_LINK_SLOT;
						wd[2] = b[31:0];
						nw = 3;
						npc = q[PAW-1:0];
						bp_n = a;
					end
				end
			end
			OP_RET: begin
				if (!stack_ok(bp_n + RETURN_SLOT) || !stack_ok(bp_n + DYNAMIC_LINK_SLOT) ||
						!stack_ok(word_at(bp_n + DYNAMIC_LINK_SLOT))) begin
					f = FLT_RANGE;
				end else begin
					a = word_at(bp_n + DYNAMIC_LINK_SLOT);
					npc = stk_mem[bp_n + RETURN_SLOT][PAW-1:0];
					sp_n = bp_n - 1;
					bp_n = a;
				end
			end
			OP_RI: begin
				if (sp_n < 0 || !stack_ok(word_at(sp_n))) begin
					f = FLT_RANGE;
				end else begin
					wa[0] = word_at(sp_n);
					wd[0] = rv;
					nw = 1;
					sp_n--;
				end
			end
			OP_WI: begin
				if (sp_n < 0) begin
					f = FLT_RANGE;
				end else begin
					r.wv = 1'b1;
					r.wval = stk_mem[sp_n];
					sp_n--;
				end
			end
			OP_WL: r.nl = 1'b1;
			OP_NEG, OP_ODD: begin
				if (sp_n < 0) begin
					f = FLT_RANGE;
				end else begin
					v = -word_at(sp_n);
					wa[0] = sp_n;
					wd[0] = (opc == OP_NEG) ? v[31:0] : {31'b0, stk_mem[sp_n][0]};
					nw = 1;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
			OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE: begin
				if (sp_n < 1) begin
					f = FLT_RANGE;
				end else begin
					x = word_at(sp_n - 1);
					y = word_at(sp_n);
					if ((opc == OP_DIV || opc == OP_MOD) && y == 0) begin
						f = FLT_DIV0;
					end else begin
						// 64-bit arithmetic holds every exact result, including the
						// most negative value divided by minus one.
						case (opc)
							OP_ADD: v = x + y;
							OP_SUB: v = x - y;
							OP_MUL: v = x * y;
							OP_DIV: v = x / y;
							OP_MOD: v = x % y;
							OP_EQ: v = (x == y);
							OP_NE: v = (x != y);
							OP_GT: v = (x > y);
							OP_GE: v = (x >= y);
							OP_LT: v = (x < y);
							default: v = (x <= y);
						endcase
						wa[0] = sp_n - 1;
						wd[0] = v[31:0];
						nw = 1;
						sp_n--;
					end
				end
			end
			default: ;
		endcase
		r.flt = f;
		if (f != FLT_NONE || hlt) begin
			r.hlt = 1'b1;
			r.npc = pc_reg;
			r.wv = 1'b0;
			r.wval = '0;
			r.nl = r.nl & hlt;
			if (commit) begin
				stopped_reg = 1'b1;
			end
		end else begin
			r.npc = npc;
			if (commit) begin
				for (int i = 0; i < nw; i++) begin
					stk_mem[wa[i]] = wd[i];
				end
				pc_reg = npc;
				sp_reg = sp_n;
				bp_reg = bp_n;
			end
		end
		return r;
	endfunction

	// Offers one request after a random gap (none in burst mode); records its expected result once taken.
	task automatic send_request(input logic [4:0] opc, input logic signed [31:0] p,
			input logic signed [31:0] q, input logic signed [31:0] rv);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation <= opc;
		p_operand <= p;
		q_operand <= q;
		read_value <= rv;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_steps.push_back(execute(1'b1, opc, p, q, rv));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_steps.size() != 0) @(posedge clk);
	endtask

	// Picks a random request that keeps the machine running.
	task automatic send_running_request();
		logic [4:0] opc;
		logic signed [31:0] p, q, rv;
		step_result_t r;
		for (int tries = 0; tries < 60; tries++) begin
			opc = $urandom_range(0, 31);
			p = $urandom;
			q = $urandom;
			rv = $urandom;
			case (opc)
				OP_LA, OP_LV, OP_CALL: begin
					p = $urandom_range(0, 3);
					if (opc != OP_CALL) begin
						q = $urandom_range(0, 16) - 4;
					end
				end
				OP_INC, OP_DEC: p = $urandom_range(0, 6);
				OP_LC: if ($urandom_range(0, 1)) p = $urandom_range(0, 40) - 10;
				default: ;
			endcase
			// Keep the stack shallow so that loads and stores land on live words.
			if (sp_reg > 200) begin
				opc = OP_DEC;
				p = $urandom_range(1, 20);
			end
			if (opc == OP_HALT) begin
				continue;
			end
			r = execute(1'b0, opc, p, q, rv);
			if (!r.hlt) begin
				send_request(opc, p, q, rv);
				return;
			end
		end
		send_request(OP_LC, $urandom, $urandom, $urandom);
	endtask

	task automatic test_directed();
		burst = 1'b0;
		send_request(OP_LC, 32'sh7fffffff, 0, 0);
		send_request(OP_LC, 1, 0, 0);
		send_request(OP_ADD, 0, 0, 0);
		send_request(OP_LC, -1, 0, 0);
		send_request(OP_DIV, 0, 0, 0);
		send_request(OP_WI, 0, 0, 0);
		send_request(OP_LC, 32'sh80000000, 0, 0);
		send_request(OP_NEG, 0, 0, 0);
		send_request(OP_LC, -1, 0, 0);
		send_request(OP_MOD, 0, 0, 0);
		send_request(OP_LC, -3, 0, 0);
		send_request(OP_ODD, 0, 0, 0);
		send_request(OP_GT, 0, 0, 0);
		send_request(OP_WI, 0, 0, 0);
		send_request(OP_JMP, -1, 0, 0);
		send_request(OP_WL, 0, 0, 0);
		send_request(OP_SPARE, -1, -1, -1);
		send_request(OP_INC, 5, 0, 0);
		send_request(OP_CALL, 0, -1, 0);
		send_request(OP_LA, 1, 0, 0);
		send_request(OP_LC, 123, 0, 0);
		send_request(OP_STORE, 0, 0, 0);
		send_request(OP_LA, 0, 2, 0);
		send_request(OP_RI, 0, 0, 32'sh80000001);
		send_request(OP_RET, 0, 0, 0);
		send_request(OP_FJMP, 100, 0, 0);
		send_request(OP_LV, 0, 0, 0);
		send_request(OP_LI, 0, 0, 0);
		drain_results();
	endtask

	task automatic test_random(input int count, input bit no_gaps);
		burst = no_gaps;
		repeat (count) send_running_request();
		drain_results();
	endtask

	// The receiver holds off while requests keep coming, so the block fills up.
	task automatic test_backpressure();
		burst = 1'b1;
		hold_left = HOLD_CYCLES;
		repeat (30) send_running_request();
		drain_results();
	endtask

	// Ends the program through one of the stopping cases, then checks that later
	// requests are answered as halted while the machine stays stopped.
	task automatic test_stop();
		burst = 1'b0;
		case ($urandom_range(0, 3))
			0: send_request(OP_HALT, $urandom, $urandom, $urandom);
			1: begin
				send_request(OP_LC, 5, 0, 0);
				send_request(OP_LC, 0, 0, 0);
				send_request(OP_DIV, 0, 0, 0);
			end
			2: send_request(OP_DEC, 32'sh7fffffff, 0, 0);
			default: send_request(OP_LV, MAX_LEVEL + 1, 0, 0);
		endcase
		repeat (8) send_request($urandom, $urandom, $urandom, $urandom);
		drain_results();
	endtask

	// Result side: random stalls, the checker and the watchdog.
	always @(posedge clk) begin
		step_result_t got, want;
		got = {next_pc, write_valid, write_value, newline, halted, fault};
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb NOT OK");
			$finish;
		end
		if (out_valid && !out_stall) begin
			if (pending_steps.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $time, got);
				failures++;
			end else begin
				want = pending_steps.pop_front();
				if (got.npc !== want.npc || got.wv !== want.wv || got.wval !== want.wval ||
						got.nl !== want.nl || got.hlt !== want.hlt || got.flt !== want.flt) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, want, got);
					failures++;
				end
			end
			out_wait = burst ? 0 : $urandom_range(0, 18);
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (out_wait > 0) begin
			out_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		operation = '0;
		p_operand = '0;
		q_operand = '0;
		read_value = '0;
		failures = 0;
		burst = 1'b0;
		hold_left = 0;
		out_wait = 0;
		idle_cycles = 0;
		foreach (stk_mem[i]) stk_mem[i] = '0;
		pc_reg = '0;
		sp_reg = -1;
		bp_reg = 0;
		stopped_reg = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(600, 1'b0);
		test_backpressure();
		test_random(500, 1'b1);
		test_random(850, 1'b0);
		test_stop();
		repeat (60) @(posedge clk);
		if (failures == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== pl0_stack_machine_step_unit.f =====
rtl/pl0_pkg.sv
rtl/pl0_stack_ram.sv
rtl/pl0_divider.sv
rtl/pl0_stack_machine_step_unit.sv
tb/tb.sv
